>>> rtl/lpt_least_loaded_assign_unit_defines.svh
// Assertion macros for the least-loaded assign unit.
// Included by the RTL files that carry concurrent checks; needs no other file.
`ifndef LPT_LEAST_LOADED_ASSIGN_UNIT_DEFINES_SVH
`define LPT_LEAST_LOADED_ASSIGN_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define LPT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed: %m");
// Expression must never be true outside reset.
`define LPT_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition: %m");
`else
`define LPT_ASSERT(label, clk, rst, prop)
`define LPT_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

>>> rtl/lpt_pkg.sv
// Shared types and constants for the least-loaded assign unit.
// No dependencies; imported by lpt_alu and lpt_least_loaded_assign_unit.
`default_nettype none
package lpt_pkg;

  localparam int MAX_MACHINES_DEF = 16;
  localparam int LOAD_BITS_DEF    = 32;

  // Fixed field widths
  localparam int FUNC_W     = 2;
  localparam int JOB_W      = 16;
  localparam int SEL_W      = 4;
  localparam int PRE_W      = 32;
  localparam int NUM_W      = 5;
  localparam int IDX_W      = 4;
  localparam int OUT_LOAD_W = 32;
  localparam int S_TDATA_W  = 56;
  localparam int M_TDATA_W  = 72;
  localparam int M_PAD_W    = 4;

  localparam logic [NUM_W-1:0] NUM_MACHINES_RST = 5'd16;

  // Function codes; the fourth code is unused
  localparam logic [FUNC_W-1:0] FUNC_ASSIGN  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PRELOAD = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ADD,
    ST_PRE,
    ST_MAX,
    ST_OUT
  } state_t;

  typedef enum logic {
    ALU_CMP,
    ALU_ADD
  } alu_op_t;

  typedef struct packed {
    alu_op_t op;
  } alu_ctrl_t;

  typedef struct packed {
    logic lt;   // a < b (compare)
    logic ovf;  // sum saturated (add)
  } alu_stat_t;

endpackage
`default_nettype wire

>>> rtl/lpt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module lpt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> rtl/lpt_alu.sv
// Shared compare / saturating-add unit: one adder serves both operations.
// Depends on lpt_pkg.
`default_nettype none
module lpt_alu #(
  parameter int LOAD_BITS = lpt_pkg::LOAD_BITS_DEF
) (
  input  wire lpt_pkg::alu_ctrl_t      ctrl,
  input  wire logic [LOAD_BITS-1:0]    a,
  input  wire logic [LOAD_BITS-1:0]    b,
  output logic      [LOAD_BITS-1:0]    result,
  output lpt_pkg::alu_stat_t           stat
);
  import lpt_pkg::*;

  localparam int SW = LOAD_BITS + 1;

  logic               is_cmp;
  logic [LOAD_BITS-1:0] b_op;
  logic [SW-1:0]      total;

  // compare is a - b: no carry out means a < b
  assign is_cmp   = (ctrl.op == ALU_CMP);
  assign b_op     = is_cmp ? ~b : b;
  assign total    = {1'b0, a} + {1'b0, b_op} + SW'(is_cmp);
  assign stat.lt  = is_cmp & ~total[LOAD_BITS];
  assign stat.ovf = ~is_cmp & total[LOAD_BITS];
  assign result   = stat.ovf ? {LOAD_BITS{1'b1}} : total[LOAD_BITS-1:0];

endmodule
`default_nettype wire

>>> rtl/lpt_least_loaded_assign_unit.sv
// Top level of the least-loaded (LPT list scheduling) assign unit.
// Depends on lpt_pkg, lpt_ram, lpt_alu and the assertion macro header.
//
//  channel | dir | handshake               | payload
//  --------+-----+-------------------------+---------------------------------------
//  s_*     | in  | s_tvalid / s_tready     | s_tdata: func, job_time, machine_select,
//          |     |                         |         preload_load
//  m_*     | out | m_tvalid / m_tready     | m_tdata: machine_index, machine_load, makespan
//          |     |                         | m_tuser: overflow
//  cfg_*   | in  | cfg_valid / cfg_ready   | cfg_data: num_machines
//
// Assign time is set by the load scan over the n active machines: one stored load is read
// from the load RAM and compared in the shared adder per cycle. Preload passes the preload
// state, then the makespan state if the select lies in the store; clear and the unused
// code go straight to the output state. Reset clears all loads at once through per-machine
// valid bits; no sweep. The result sits in an output register, so a new transaction is
// taken while it waits; a stalled result only holds the unit once the next result is ready.
`default_nettype none
`include "lpt_least_loaded_assign_unit_defines.svh"
module lpt_least_loaded_assign_unit #(
  parameter int MAX_MACHINES = lpt_pkg::MAX_MACHINES_DEF,
  parameter int LOAD_BITS    = lpt_pkg::LOAD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // [1:0] func, [17:2] job_time, [21:18] machine_select, [53:22] preload_load
  input  wire logic [lpt_pkg::S_TDATA_W-1:0]  s_tdata,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [3:0] machine_index, [35:4] machine_load, [67:36] makespan
  output logic      [lpt_pkg::M_TDATA_W-1:0]  m_tdata,
  // [0] overflow
  output logic                                m_tuser,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  input  wire logic [lpt_pkg::NUM_W-1:0]      cfg_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready
);
  import lpt_pkg::*;

  localparam int IW = (MAX_MACHINES > 1) ? $clog2(MAX_MACHINES) : 1;  // RAM index
  localparam int CW = $clog2(MAX_MACHINES + 1);                       // count
  localparam int NW = (CW > NUM_W) ? CW : NUM_W;

  // input field views
  logic [FUNC_W-1:0] in_func;
  assign in_func = s_tdata[1:0];

  state_t state, state_next;

  // configuration
  logic [NUM_W-1:0] num_machines;
  logic [CW-1:0]    n_active;
  logic [NW-1:0]    num_ext;

  // scheduler state
  logic [MAX_MACHINES-1:0] vld, vld_next;
  logic [LOAD_BITS-1:0]    makespan, makespan_next;
  logic                    ovf_seen, ovf_seen_next;

  // scan sequencer
  logic [CW-1:0]        rd_idx, rd_idx_next;
  logic                 rd_pend, rd_pend_next;
  logic [IW-1:0]        rd_q_idx, rd_q_idx_next;
  logic [LOAD_BITS-1:0] lo, lo_next;
  logic [IW-1:0]        best, best_next;
  logic                 scan_issue;
  logic [LOAD_BITS-1:0] cand;

  // latched transaction payload
  logic [JOB_W-1:0] job_time;
  logic [SEL_W-1:0] sel;
  logic [PRE_W-1:0] pre;

  // result
  logic [IDX_W-1:0]     res_idx, res_idx_next;
  logic [LOAD_BITS-1:0] res_load, res_load_next;
  logic                 out_load;
  logic                 s_fire;

  // preload checks
  logic [63:0]          pre_w;
  logic                 pre_sat;
  logic [LOAD_BITS-1:0] pre_val;
  logic                 sel_ok;
  logic [IW-1:0]        sel_addr;

  // RAM and shared unit hookup
  logic                 ram_we;
  logic [IW-1:0]        ram_waddr;
  logic [LOAD_BITS-1:0] ram_wdata;
  logic [LOAD_BITS-1:0] ram_rdata;
  alu_ctrl_t            alu_ctrl;
  alu_stat_t            alu_stat;
  logic [LOAD_BITS-1:0] alu_a, alu_b, alu_result;

  lpt_ram #(
    .WIDTH (LOAD_BITS),
    .DEPTH (MAX_MACHINES)
  ) u_loads (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  lpt_alu #(
    .LOAD_BITS (LOAD_BITS)
  ) u_alu (
    .ctrl   (alu_ctrl),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_result),
    .stat   (alu_stat)
  );

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);
  assign s_fire    = s_tvalid && s_tready;

  // Active machine count: zero acts as one, clamp at the store depth
  always_comb begin
    num_ext = NW'(num_machines);
    if (num_ext == '0) begin
      n_active = CW'(1);
    end else if (num_ext > NW'(MAX_MACHINES)) begin
      n_active = CW'(MAX_MACHINES);
    end else begin
      n_active = CW'(num_ext);
    end
  end

  // Unwritten entries (since reset or clear) read as zero
  assign scan_issue = (rd_idx < n_active);
  assign cand       = vld[rd_q_idx] ? ram_rdata : '0;

  // Preload saturates to the largest load; selects beyond the store write nothing
  assign pre_w    = 64'(pre);
  assign pre_sat  = (pre_w >> LOAD_BITS) != 64'd0;
  assign pre_val  = pre_sat ? {LOAD_BITS{1'b1}} : LOAD_BITS'(pre_w);
  assign sel_ok   = 32'(sel) < MAX_MACHINES;
  assign sel_addr = IW'(sel);

  // Next state and datapath control
  always_comb begin
    state_next    = state;
    vld_next      = vld;
    makespan_next = makespan;
    ovf_seen_next = ovf_seen;
    rd_idx_next   = rd_idx;
    rd_pend_next  = rd_pend;
    rd_q_idx_next = rd_q_idx;
    lo_next       = lo;
    best_next     = best;
    res_idx_next  = res_idx;
    res_load_next = res_load;
    out_load      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = best;
    ram_wdata     = alu_result;
    alu_ctrl.op   = ALU_CMP;
    alu_a         = makespan;
    alu_b         = res_load;

    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          unique case (in_func)
            FUNC_ASSIGN: begin
              rd_idx_next  = '0;
              rd_pend_next = 1'b0;
              state_next   = ST_SCAN;
            end
            FUNC_PRELOAD: begin
              state_next = ST_PRE;
            end
            FUNC_CLEAR: begin
              vld_next      = '0;
              makespan_next = '0;
              ovf_seen_next = 1'b0;
              res_idx_next  = '0;
              res_load_next = '0;
              state_next    = ST_OUT;
            end
            default: begin
              // unused code: no state change, zero index and load
              res_idx_next  = '0;
              res_load_next = '0;
              state_next    = ST_OUT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // one read issued, one compare retired per cycle
        alu_ctrl.op   = ALU_CMP;
        alu_a         = cand;
        alu_b         = lo;
        rd_idx_next   = rd_idx + CW'(scan_issue);
        rd_pend_next  = scan_issue;
        rd_q_idx_next = rd_idx[IW-1:0];
        if (rd_pend && ((rd_q_idx == '0) || alu_stat.lt)) begin
          lo_next   = cand;
          best_next = rd_q_idx;
        end
        if (!scan_issue) begin
          state_next = ST_ADD;
        end
      end

      ST_ADD: begin
        alu_ctrl.op          = ALU_ADD;
        alu_a                = lo;
        alu_b                = LOAD_BITS'(job_time);
        res_load_next        = alu_result;
        res_idx_next         = IDX_W'(best);
        ovf_seen_next        = ovf_seen | alu_stat.ovf;
        ram_we               = 1'b1;
        ram_waddr            = best;
        ram_wdata            = alu_result;
        vld_next[best]       = 1'b1;
        state_next           = ST_MAX;
      end

      ST_PRE: begin
        res_idx_next = sel;
        if (sel_ok) begin
          res_load_next      = pre_val;
          ovf_seen_next      = ovf_seen | pre_sat;
          ram_we             = 1'b1;
          ram_waddr          = sel_addr;
          ram_wdata          = pre_val;
          vld_next[sel_addr] = 1'b1;
          state_next         = ST_MAX;
        end else begin
          res_load_next = '0;
          state_next    = ST_OUT;
        end
      end

      ST_MAX: begin
        // makespan only grows
        alu_ctrl.op = ALU_CMP;
        alu_a       = makespan;
        alu_b       = res_load;
        if (alu_stat.lt) begin
          makespan_next = res_load;
        end
        state_next = ST_OUT;
      end

      ST_OUT: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      num_machines <= NUM_MACHINES_RST;
      vld          <= '0;
      makespan     <= '0;
      ovf_seen     <= 1'b0;
      rd_pend      <= 1'b0;
      rd_idx       <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        num_machines <= cfg_data;
      end
      vld      <= vld_next;
      makespan <= makespan_next;
      ovf_seen <= ovf_seen_next;
      rd_pend  <= rd_pend_next;
      rd_idx   <= rd_idx_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (s_fire) begin
      job_time <= s_tdata[17:2];
      sel      <= s_tdata[21:18];
      pre      <= s_tdata[53:22];
    end
    rd_q_idx <= rd_q_idx_next;
    lo       <= lo_next;
    best     <= best_next;
    res_idx  <= res_idx_next;
    res_load <= res_load_next;
    if (out_load) begin
      m_tdata <= {{M_PAD_W{1'b0}}, OUT_LOAD_W'(makespan), OUT_LOAD_W'(res_load), res_idx};
      m_tuser <= ovf_seen;
    end
  end

  // Chosen machine always lies among the active ones
  `LPT_ASSERT(a_best_in_range, clk, rst, (state == ST_ADD) |-> (CW'(best) < n_active))
  // Scan never retires a read beyond the active machines
  `LPT_ASSERT_NEVER(a_scan_bound, clk, rst, (state == ST_SCAN) && rd_pend && (CW'(rd_q_idx) >= n_active))
  // Makespan falls only on a clear
  `LPT_ASSERT(a_makespan_grows, clk, rst, !(s_fire && (in_func == FUNC_CLEAR)) |=> (makespan >= $past(makespan)))
  // A new result appears only out of the output state
  `LPT_ASSERT(a_result_from_out, clk, rst, $rose(m_tvalid) |-> ($past(state) == ST_OUT))

endmodule
`default_nettype wire
